[sv/anfp_pkg.sv]
// shared types and constants for the advertising name filter parser
// no dependencies; used by every module of the block

package anfp_pkg;

    localparam int MAX_ENTRIES = 4;
    localparam int FW_WIDTH    = 27;
    localparam int FW_EN_BIT   = 26;
    localparam int FW_LEN_LSB  = 24;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_ADDR_W  = CFG_INDEX_W + 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_FILTERING_ON   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FILTER_WORD_0  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_FILTER_WORD_1  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FILTER_WORD_2  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FILTER_WORD_3  = 3'd4;

    localparam logic [7:0] AD_TYPE_SHORT_NAME    = 8'h08;
    localparam logic [7:0] AD_TYPE_COMPLETE_NAME = 8'h09;

    typedef logic [FW_WIDTH-1:0] filter_word_t;

    typedef struct packed {
        logic                   name_seen;
        logic                   name_kind;
        logic [4:0]             name_start;
        logic [4:0]             name_received;
        logic [MAX_ENTRIES-1:0] match_flags;
    } report_t;

    function automatic logic [1:0] prefix_len(input filter_word_t w, input int max_bytes);
        logic [1:0] l;
        l = w[FW_LEN_LSB +: 2];
        return (int'(l) > max_bytes) ? 2'(max_bytes) : l;
    endfunction

endpackage

[sv/anfp_regs.sv]
// configuration register bank on the apb-style port
// depends on anfp_pkg for register codes and filter word type

module anfp_regs (
    input  logic                                                 aclk,
    input  logic                                                 aresetn,
    input  logic                                                 psel,
    input  logic                                                 penable,
    input  logic                                                 pwrite,
    input  logic [anfp_pkg::CFG_ADDR_W-1:0]                      paddr,
    input  logic [anfp_pkg::CFG_DATA_W-1:0]                      pwdata,
    output logic [anfp_pkg::CFG_DATA_W-1:0]                      prdata,
    output logic                                                 filtering_on,
    output anfp_pkg::filter_word_t [anfp_pkg::MAX_ENTRIES-1:0]   filter_words
);

    logic                                               filtering_on_reg;
    anfp_pkg::filter_word_t [anfp_pkg::MAX_ENTRIES-1:0] filter_words_reg;
    logic [anfp_pkg::CFG_INDEX_W-1:0]                   reg_index;
    logic                                               wr_en;
    anfp_pkg::filter_word_t                             wdata_word;

    assign reg_index  = paddr[anfp_pkg::CFG_ADDR_W-1:2];
    assign wr_en      = psel && penable && pwrite;
    assign wdata_word = pwdata[anfp_pkg::FW_WIDTH-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filtering_on_reg <= 1'b0;
            filter_words_reg <= '0;
        end else if (wr_en) begin
            unique case (reg_index)
                anfp_pkg::REG_FILTERING_ON:  filtering_on_reg    <= pwdata[0];
                anfp_pkg::REG_FILTER_WORD_0: filter_words_reg[0] <= wdata_word;
                anfp_pkg::REG_FILTER_WORD_1: filter_words_reg[1] <= wdata_word;
                anfp_pkg::REG_FILTER_WORD_2: filter_words_reg[2] <= wdata_word;
                anfp_pkg::REG_FILTER_WORD_3: filter_words_reg[3] <= wdata_word;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_index)
            anfp_pkg::REG_FILTERING_ON:  prdata = {31'b0, filtering_on_reg};
            anfp_pkg::REG_FILTER_WORD_0: prdata = 32'(filter_words_reg[0]);
            anfp_pkg::REG_FILTER_WORD_1: prdata = 32'(filter_words_reg[1]);
            anfp_pkg::REG_FILTER_WORD_2: prdata = 32'(filter_words_reg[2]);
            anfp_pkg::REG_FILTER_WORD_3: prdata = 32'(filter_words_reg[3]);
            default:                     prdata = '0;
        endcase
    end

    assign filtering_on = filtering_on_reg;
    assign filter_words = filter_words_reg;

endmodule

[sv/anfp_parser.sv]
// ad structure walker: per-byte state update and prefix compare
// depends on anfp_pkg for report_t, filter words and ad type codes

module anfp_parser #(
    parameter int NUM_FILTERS      = 4,
    parameter int PREFIX_BYTES     = 3,
    parameter int MAX_REPORT_BYTES = 31
) (
    input  logic                                                 aclk,
    input  logic                                                 aresetn,
    input  logic                                                 accept,
    input  logic [7:0]                                           data_byte,
    input  logic                                                 last,
    input  anfp_pkg::filter_word_t [anfp_pkg::MAX_ENTRIES-1:0]   filter_words,
    output anfp_pkg::report_t                                    report_next
);

    localparam int NUM_ENTRIES = (NUM_FILTERS > anfp_pkg::MAX_ENTRIES) ?
                                 anfp_pkg::MAX_ENTRIES : NUM_FILTERS;

    localparam logic [1:0] PH_LEN  = 2'd0;
    localparam logic [1:0] PH_TYPE = 2'd1;
    localparam logic [1:0] PH_NAME = 2'd2;
    localparam logic [1:0] PH_IDLE = 2'd3;

    logic [4:0]              byte_position_reg, byte_position_next;
    logic [8:0]              next_header_position_reg, next_header_position_next;
    logic [1:0]              parse_phase_reg, parse_phase_next;
    logic [7:0]              structure_length_reg, structure_length_next;
    anfp_pkg::report_t       report_reg, report_fresh;
    logic [1:0]              rx_sel;

    assign rx_sel = report_reg.name_received[1:0];

    always_comb begin
        report_fresh             = '0;
        report_fresh.match_flags = '1;
    end

    always_comb begin
        byte_position_next        = byte_position_reg;
        next_header_position_next = next_header_position_reg;
        parse_phase_next          = parse_phase_reg;
        structure_length_next     = structure_length_reg;
        report_next               = report_reg;
        if (byte_position_reg < 5'(MAX_REPORT_BYTES)) begin
            byte_position_next = byte_position_reg + 5'd1;
            unique case (parse_phase_reg)
                PH_LEN: begin
                    if (9'(byte_position_reg) == next_header_position_reg) begin
                        if (byte_position_reg >= 5'(MAX_REPORT_BYTES - 1) ||
                            data_byte == 8'd0) begin
                            parse_phase_next = PH_IDLE;
                        end else begin
                            structure_length_next = data_byte;
                            parse_phase_next      = PH_TYPE;
                        end
                    end
                end
                PH_TYPE: begin
                    if (data_byte == anfp_pkg::AD_TYPE_SHORT_NAME ||
                        data_byte == anfp_pkg::AD_TYPE_COMPLETE_NAME) begin
                        report_next.name_seen     = 1'b1;
                        report_next.name_kind     = (data_byte == anfp_pkg::AD_TYPE_COMPLETE_NAME);
                        report_next.name_start    = byte_position_reg + 5'd1;
                        report_next.name_received = 5'd0;
                        report_next.match_flags   = '1;
                        if (structure_length_reg <= 8'd1) begin
                            parse_phase_next = PH_IDLE;
                        end else begin
                            parse_phase_next = PH_NAME;
                        end
                    end else begin
                        next_header_position_next = 9'(byte_position_reg) +
                                                    9'(structure_length_reg);
                        parse_phase_next          = PH_LEN;
                    end
                end
                PH_NAME: begin
                    for (int i = 0; i < NUM_ENTRIES; i++) begin
                        if (report_reg.name_received <
                            5'(anfp_pkg::prefix_len(filter_words[i], PREFIX_BYTES))) begin
                            if (filter_words[i][{rx_sel, 3'b000} +: 8] != data_byte) begin
                                report_next.match_flags[i] = 1'b0;
                            end
                        end
                    end
                    report_next.name_received = report_reg.name_received + 5'd1;
                    if (9'(report_next.name_received) + 9'd1 >= 9'(structure_length_reg)) begin
                        parse_phase_next = PH_IDLE;
                    end
                end
                PH_IDLE: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_position_reg        <= '0;
            next_header_position_reg <= '0;
            parse_phase_reg          <= PH_LEN;
            structure_length_reg     <= '0;
            report_reg               <= report_fresh;
        end else if (accept) begin
            if (last) begin
                byte_position_reg        <= '0;
                next_header_position_reg <= '0;
                parse_phase_reg          <= PH_LEN;
                structure_length_reg     <= '0;
                report_reg               <= report_fresh;
            end else begin
                byte_position_reg        <= byte_position_next;
                next_header_position_reg <= next_header_position_next;
                parse_phase_reg          <= parse_phase_next;
                structure_length_reg     <= structure_length_next;
                report_reg               <= report_next;
            end
        end
    end

endmodule

[sv/anfp_result.sv]
// filter decision and two-entry output stage for finished reports
// depends on anfp_pkg for report_t, filter words and prefix_len

module anfp_result #(
    parameter int NUM_FILTERS  = 4,
    parameter int PREFIX_BYTES = 3
) (
    input  logic                                                 aclk,
    input  logic                                                 aresetn,
    input  logic                                                 push,
    input  anfp_pkg::report_t                                    report,
    input  logic                                                 filtering_on,
    input  anfp_pkg::filter_word_t [anfp_pkg::MAX_ENTRIES-1:0]   filter_words,
    output logic                                                 in_ready,
    output logic                                                 m_valid,
    input  logic                                                 m_ready,
    output logic                                                 m_name_found,
    output logic                                                 m_accepted,
    output logic                                                 m_name_kind,
    output logic [4:0]                                           m_name_offset,
    output logic [4:0]                                           m_name_length,
    output logic                                                 m_filter_hit,
    output logic [1:0]                                           m_hit_index
);

    localparam int NUM_ENTRIES = (NUM_FILTERS > anfp_pkg::MAX_ENTRIES) ?
                                 anfp_pkg::MAX_ENTRIES : NUM_FILTERS;

    typedef struct packed {
        logic       name_found;
        logic       accepted;
        logic       name_kind;
        logic [4:0] name_offset;
        logic [4:0] name_length;
        logic       filter_hit;
        logic [1:0] hit_index;
    } result_t;

    result_t result_new, main_reg, skid_reg;
    logic    main_valid_reg, skid_valid_reg;
    logic    pop;

    always_comb begin
        result_new = '0;
        for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
            if (filtering_on && report.name_seen &&
                filter_words[i][anfp_pkg::FW_EN_BIT] && report.match_flags[i] &&
                5'(anfp_pkg::prefix_len(filter_words[i], PREFIX_BYTES)) <=
                report.name_received) begin
                result_new.filter_hit = 1'b1;
                result_new.hit_index  = 2'(i);
            end
        end
        result_new.name_found = report.name_seen;
        result_new.accepted   = report.name_seen && (!filtering_on || result_new.filter_hit);
        if (report.name_seen) begin
            result_new.name_kind   = report.name_kind;
            result_new.name_offset = report.name_start;
            result_new.name_length = report.name_received;
        end
    end

    assign pop      = main_valid_reg && m_ready;
    assign in_ready = !skid_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (pop) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (pop) begin
            main_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (pop) begin
                main_reg <= skid_reg;
            end
        end else if (push) begin
            if (!main_valid_reg || pop) begin
                main_reg <= result_new;
            end else begin
                skid_reg <= result_new;
            end
        end
    end

    assign m_valid       = main_valid_reg;
    assign m_name_found  = main_reg.name_found;
    assign m_accepted    = main_reg.accepted;
    assign m_name_kind   = main_reg.name_kind;
    assign m_name_offset = main_reg.name_offset;
    assign m_name_length = main_reg.name_length;
    assign m_filter_hit  = main_reg.filter_hit;
    assign m_hit_index   = main_reg.hit_index;

endmodule

[sv/adv_name_filter_parser_top.sv]
// top level of the advertising report local name filter
// depends on anfp_pkg, anfp_regs, anfp_parser and anfp_result

// Takes one advertising report byte per cycle and gives one request per
// report, at its last byte, with the first local name found and the prefix
// filter verdict. Each byte is parsed in the cycle it is accepted, so the
// sustained rate is one byte per clock; a result is formed from the parser
// state and the last byte in that same cycle and lands in a two-entry output
// stage, so input stalls only when both entries hold results not yet taken.
// Filter registers must be written over the apb-style port only while no
// report is in progress; the block itself does not enforce this.

module adv_name_filter_parser_top #(
    parameter int NUM_FILTERS      = 4,
    parameter int PREFIX_BYTES     = 3,
    parameter int MAX_REPORT_BYTES = 31
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [7:0]                          s_data_byte,
    input  logic                                s_last,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_name_found,
    output logic                                m_accepted,
    output logic                                m_name_kind,
    output logic [4:0]                          m_name_offset,
    output logic [4:0]                          m_name_length,
    output logic                                m_filter_hit,
    output logic [1:0]                          m_hit_index,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [anfp_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [anfp_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [anfp_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready
);

    logic                                               filtering_on;
    anfp_pkg::filter_word_t [anfp_pkg::MAX_ENTRIES-1:0] filter_words;
    anfp_pkg::report_t                                  report_next;
    logic                                               accept;

    assign pready = 1'b1;
    assign accept = s_valid && s_ready;

    anfp_regs u_regs (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .filtering_on (filtering_on),
        .filter_words (filter_words)
    );

    anfp_parser #(
        .NUM_FILTERS      (NUM_FILTERS),
        .PREFIX_BYTES     (PREFIX_BYTES),
        .MAX_REPORT_BYTES (MAX_REPORT_BYTES)
    ) u_parser (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .accept       (accept),
        .data_byte    (s_data_byte),
        .last         (s_last),
        .filter_words (filter_words),
        .report_next  (report_next)
    );

    anfp_result #(
        .NUM_FILTERS  (NUM_FILTERS),
        .PREFIX_BYTES (PREFIX_BYTES)
    ) u_result (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .push          (accept && s_last),
        .report        (report_next),
        .filtering_on  (filtering_on),
        .filter_words  (filter_words),
        .in_ready      (s_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_name_found  (m_name_found),
        .m_accepted    (m_accepted),
        .m_name_kind   (m_name_kind),
        .m_name_offset (m_name_offset),
        .m_name_length (m_name_length),
        .m_filter_hit  (m_filter_hit),
        .m_hit_index   (m_hit_index)
    );

    // input stalls only behind a full output stage
    a_stall_needs_result: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with no pending result");

    // a byte that is not last never creates a request
    a_no_spurious_result: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !s_last && !m_valid |=> !m_valid)
        else $error("result appeared without a last byte");

    a_accept_needs_name: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_accepted || m_filter_hit) |-> m_name_found)
        else $error("accepted without a name");

    a_empty_when_no_name: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_name_found |-> m_name_offset == 5'd0 && m_name_length == 5'd0
                                     && !m_name_kind && m_hit_index == 2'd0)
        else $error("name fields set with no name");

endmodule
